@@ src/escaped_line_command_parser_core_assert.svh @@
// Assertion macros shared by the checker of the escaped line command parser.
// Needs signals clk and rst_n in the scope of use.
`ifndef ESCAPED_LINE_COMMAND_PARSER_CORE_ASSERT_SVH
`define ESCAPED_LINE_COMMAND_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define ELCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/elcp_pkg.sv @@
// Types and constants of the escaped line command parser.
// No dependencies.
package elcp_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0] BYTE_LF   = 8'd10;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_ESC  = 8'd27;
    localparam logic [7:0] BYTE_BANG = 8'h21;
    localparam logic [7:0] BYTE_PLUS = 8'd43;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_CMD      = 2'd1,
        KIND_BREAK    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } line_kind_t;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_SINGLE,
        RD_READ,
        RD_LOAD
    } rd_state_t;

    // emission request from the line front end to the readout
    typedef struct packed {
        logic             start;
        logic             single;
        line_kind_t       kind;
        logic [CNT_W-1:0] len;
    } rd_req_t;

endpackage

@@ src/elcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module elcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/elcp_readout.sv @@
// Line readout: walks the line store and drives the output register.
// Depends on elcp_pkg.
module elcp_readout (
    input  logic                          clk,
    input  logic                          rst_n,
    input  elcp_pkg::rd_req_t             req,
    output logic                          busy,
    output logic                          rd_en,
    output logic [elcp_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // out_byte
    output logic [1:0]                    m_axis_tuser,  // line_kind
    output logic                          m_axis_tlast   // last
);

    elcp_pkg::rd_state_t  state_reg, state_next;
    logic [elcp_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [elcp_pkg::CNT_W-1:0]  len_reg, len_next;
    elcp_pkg::line_kind_t kind_reg, kind_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    elcp_pkg::line_kind_t out_kind_reg, out_kind_next;
    logic                 out_last_reg, out_last_next;

    logic slot_free;
    logic is_last;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign is_last   = (elcp_pkg::CNT_W'(idx_reg) + elcp_pkg::CNT_W'(1)) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elcp_pkg::RD_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;

        unique case (state_reg)
            elcp_pkg::RD_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    len_next   = req.len;
                    kind_next  = req.kind;
                    state_next = req.single ? elcp_pkg::RD_SINGLE : elcp_pkg::RD_READ;
                end
            end
            elcp_pkg::RD_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    out_kind_next  = kind_reg;
                    out_last_next  = 1'b1;
                    state_next     = elcp_pkg::RD_IDLE;
                end
            end
            elcp_pkg::RD_READ:
            begin
                rd_en      = 1'b1;
                state_next = elcp_pkg::RD_LOAD;
            end
            elcp_pkg::RD_LOAD:
            begin
                // read data holds until the slot frees up
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    out_kind_next  = kind_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = elcp_pkg::RD_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + elcp_pkg::ADDR_W'(1);
                        state_next = elcp_pkg::RD_READ;
                    end
                end
            end
            default:
            begin
                state_next = elcp_pkg::RD_IDLE;
            end
        endcase
    end

    assign busy          = state_reg != elcp_pkg::RD_IDLE;
    assign rd_addr       = idx_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ src/escaped_line_command_parser_core.sv @@
// Escaped line command parser: one received byte per input word builds a
// line in a 64-byte store; a terminated or full line leaves as a run of
// output words (or one break / overflow word). Input takes one byte per cycle
// while a line fills; once a line ends the input stalls for the readout,
// which reads each line byte from the store and then puts it in the output
// register, and which waits there whenever the output is stalled.
// The final word of a run may still wait at the output while new bytes come
// in. No clearing pass after reset. Depends on elcp_pkg, elcp_ram, elcp_readout.
module escaped_line_command_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic [1:0] m_axis_tuser,   // line_kind
    output logic       m_axis_tlast    // last
);

    logic [elcp_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic esc_reg, esc_next;
    logic plus_esc_reg, plus_esc_next;
    logic first_plus_reg, first_plus_next;
    logic second_plus_reg, second_plus_next;
    logic third_bang_reg, third_bang_next;

    logic [elcp_pkg::CNT_W-1:0] fill_inc;
    logic             accept;
    logic             is_crlf, is_esc, is_plus;
    logic             store, terminate;
    logic             cmd_start;
    logic             busy;
    logic             rd_en;
    logic [elcp_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    elcp_pkg::rd_req_t req;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_crlf  = (s_axis_tdata == elcp_pkg::BYTE_CR) || (s_axis_tdata == elcp_pkg::BYTE_LF);
    assign is_esc   = s_axis_tdata == elcp_pkg::BYTE_ESC;
    assign is_plus  = s_axis_tdata == elcp_pkg::BYTE_PLUS;
    assign fill_inc = fill_reg + elcp_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            esc_reg      <= 1'b0;
            plus_esc_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            esc_reg      <= esc_next;
            plus_esc_reg <= plus_esc_next;
        end
    end

    // leading-byte flags are only looked at once those bytes are in
    always_ff @(posedge clk)
    begin
        first_plus_reg  <= first_plus_next;
        second_plus_reg <= second_plus_next;
        third_bang_reg  <= third_bang_next;
    end

    always_comb
    begin
        fill_next        = fill_reg;
        esc_next         = esc_reg;
        plus_esc_next    = plus_esc_reg;
        first_plus_next  = first_plus_reg;
        second_plus_next = second_plus_reg;
        third_bang_next  = third_bang_reg;
        store            = 1'b0;
        terminate        = 1'b0;
        cmd_start        = 1'b0;
        req              = '0;

        if (accept)
        begin
            priority if (is_crlf)
            begin
                if (esc_reg)
                begin
                    store    = 1'b1;
                    esc_next = 1'b0;
                end
                else if (fill_reg != '0)
                begin
                    terminate = 1'b1;
                end
            end
            else if (is_esc)
            begin
                store    = esc_reg;
                esc_next = !esc_reg;
            end
            else if (is_plus)
            begin
                if (esc_reg && (fill_reg < elcp_pkg::CNT_W'(2)))
                begin
                    plus_esc_next = 1'b1;
                end
                esc_next = 1'b0;
                store    = 1'b1;
            end
            else
            begin
                store    = 1'b1;
                esc_next = 1'b0;
            end

            if (terminate)
            begin
                cmd_start = (fill_reg > elcp_pkg::CNT_W'(2)) && first_plus_reg
                            && second_plus_reg && !plus_esc_reg;
                req.start  = 1'b1;
                req.single = cmd_start && third_bang_reg;
                req.len    = fill_reg;
                if (cmd_start)
                begin
                    req.kind = third_bang_reg ? elcp_pkg::KIND_BREAK : elcp_pkg::KIND_CMD;
                end
                else
                begin
                    req.kind = elcp_pkg::KIND_DATA;
                end
                fill_next     = '0;
                esc_next      = 1'b0;
                plus_esc_next = 1'b0;
            end
            else if (store)
            begin
                if (fill_reg == elcp_pkg::CNT_W'(0))
                begin
                    first_plus_next = is_plus;
                end
                if (fill_reg == elcp_pkg::CNT_W'(1))
                begin
                    second_plus_next = is_plus;
                end
                if (fill_reg == elcp_pkg::CNT_W'(2))
                begin
                    third_bang_next = s_axis_tdata == elcp_pkg::BYTE_BANG;
                end

                if (fill_inc == elcp_pkg::CNT_W'(elcp_pkg::BUF_DEPTH))
                begin
                    // full store: a "++" line overflows regardless of escapes
                    cmd_start     = first_plus_reg && second_plus_reg;
                    req.start     = 1'b1;
                    req.single    = cmd_start;
                    req.kind      = cmd_start ? elcp_pkg::KIND_OVERFLOW : elcp_pkg::KIND_DATA;
                    req.len       = fill_inc;
                    fill_next     = '0;
                    esc_next      = 1'b0;
                    plus_esc_next = 1'b0;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end
        end
    end

    assign s_axis_tready = !busy;

    elcp_ram #(
        .WIDTH (8),
        .DEPTH (elcp_pkg::BUF_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept && store),
        .wr_addr (fill_reg[elcp_pkg::ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    elcp_readout u_readout (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ src/elcp_checker.sv @@
// Port-level checks for the escaped line command parser, bound to the top level.
// Depends on elcp_pkg and escaped_line_command_parser_core_assert.svh.
`include "escaped_line_command_parser_core_assert.svh"

module elcp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic single_kind;
    logic mid_run_taken;

    assign single_kind   = (m_axis_tuser == elcp_pkg::KIND_BREAK)
                        || (m_axis_tuser == elcp_pkg::KIND_OVERFLOW);
    assign mid_run_taken = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

    `ELCP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast), "stalled output word changed")
    `ELCP_ASSERT_NOW(a_single_word, m_axis_tvalid && single_kind,
        (m_axis_tdata == 8'd0) && m_axis_tlast, "break or overflow word not a lone zero word")
    `ELCP_ASSERT_NOW(a_stall_in_run, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
        "input taken in the middle of a run")
    `ELCP_ASSERT_NXT(a_run_kind, mid_run_taken,
        !m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser)),
        "line kind changed within a run")

endmodule

bind escaped_line_command_parser_core elcp_checker u_elcp_checker (.*);
